FILE: design/smsc_pkg.sv
// Shared types, register indexes and the coil sequence of the stepper sequencer.
`default_nettype none

package smsc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PERIOD_NONE   = 3'd0;
  localparam logic [2:0] REG_PERIOD_FIRST  = 3'd1;
  localparam logic [2:0] REG_PERIOD_SECOND = 3'd2;
  localparam logic [2:0] REG_PERIOD_BOTH   = 3'd3;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_PERIOD_NONE   = 16'd10;
  localparam logic [15:0] RST_PERIOD_FIRST  = 16'd20;
  localparam logic [15:0] RST_PERIOD_SECOND = 16'd15;
  localparam logic [15:0] RST_PERIOD_BOTH   = 16'd12;
  localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd100;

  // One result word, last field in the lowest bits
  typedef struct packed {
    logic       sampled;
    logic       stepped;
    logic [3:0] coil_pattern;
  } smsc_result_t;

  // Coil drive bits for each of the eight sequence positions
  function automatic logic [3:0] coil_lookup(input logic [2:0] pos);
    logic [3:0] coil;
    case (pos)
      3'd0:    coil = 4'hA;
      3'd1:    coil = 4'h8;
      3'd2:    coil = 4'h9;
      3'd3:    coil = 4'h1;
      3'd4:    coil = 4'h5;
      3'd5:    coil = 4'h4;
      3'd6:    coil = 4'h6;
      default: coil = 4'h2;
    endcase
    return coil;
  endfunction

endpackage

`default_nettype wire

FILE: design/smsc_core.sv
// Countdowns, button decode and sequence position of the stepper sequencer.
`default_nettype none

module smsc_core
  import smsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         tick_en,
  input  wire logic         first_button,
  input  wire logic         second_button,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output smsc_result_t      result
);

  logic [15:0] period_r [0:3];
  logic [15:0] sample_period_r;

  logic [15:0] sample_cnt_r, sample_cnt_nxt;
  logic [15:0] step_cnt_r,   step_cnt_nxt;
  logic [15:0] step_reload_r, step_reload_nxt;
  logic [2:0]  position_r,   position_nxt;
  logic        ccw_r,        ccw_nxt;
  logic        full_r,       full_nxt;

  logic        sample_due;
  logic        step_due;
  logic [1:0]  btn_sel;
  logic [2:0]  delta;
  logic [15:0] sample_reloaded;
  logic [15:0] step_reloaded;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r[0]     <= RST_PERIOD_NONE;
      period_r[1]     <= RST_PERIOD_FIRST;
      period_r[2]     <= RST_PERIOD_SECOND;
      period_r[3]     <= RST_PERIOD_BOTH;
      sample_period_r <= RST_SAMPLE_PERIOD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PERIOD_NONE:   period_r[0]     <= cfg_data;
        REG_PERIOD_FIRST:  period_r[1]     <= cfg_data;
        REG_PERIOD_SECOND: period_r[2]     <= cfg_data;
        REG_PERIOD_BOTH:   period_r[3]     <= cfg_data;
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample buttons first, then step with the freshly decoded settings
  always_comb begin
    btn_sel    = {second_button, first_button};
    sample_due = (sample_cnt_r == 16'd0);
    step_due   = (step_cnt_r == 16'd0);

    ccw_nxt         = sample_due ? second_button    : ccw_r;
    full_nxt        = sample_due ? first_button     : full_r;
    step_reload_nxt = sample_due ? period_r[btn_sel] : step_reload_r;
    sample_reloaded = sample_due ? sample_period_r  : sample_cnt_r;

    delta = full_nxt ? 3'd2 : 3'd1;
    if (!step_due) begin
      position_nxt = position_r;
    end else if (ccw_nxt) begin
      position_nxt = position_r - delta;
    end else begin
      position_nxt = position_r + delta;
    end
    step_reloaded = step_due ? step_reload_nxt : step_cnt_r;

    // Both countdowns reload from their period at zero
    sample_cnt_nxt = sample_reloaded - 16'd1;
    step_cnt_nxt   = step_reloaded - 16'd1;

    result.coil_pattern = coil_lookup(position_nxt);
    result.stepped      = step_due;
    result.sampled      = sample_due;
  end

  // Advance state once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r  <= RST_SAMPLE_PERIOD;
      step_cnt_r    <= RST_PERIOD_NONE;
      step_reload_r <= RST_PERIOD_NONE;
      position_r    <= 3'd0;
      ccw_r         <= 1'b0;
      full_r        <= 1'b0;
    end else if (tick_en) begin
      sample_cnt_r  <= sample_cnt_nxt;
      step_cnt_r    <= step_cnt_nxt;
      step_reload_r <= step_reload_nxt;
      position_r    <= position_nxt;
      ccw_r         <= ccw_nxt;
      full_r        <= full_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/stepper_motor_step_controller.sv
// Top level of the unipolar stepper half/full step sequencer.
//
//   channel | direction | payload
//   --------+-----------+-------------------------------------------------
//   in_     | slave     | tick word: button levels
//   out_    | master    | result word: coil pattern, stepped, sampled
//   cfg_    | write     | five 16-bit periods, index 0..4
//
// One tick word is taken every cycle while in_tready is high; its result is registered.
// The state update is one pass of countdown compare, mux and 3-bit add.
// An output register plus a one-word skid register hold results while
// out_tready is low, so in_tready drops only once both are full.
// rst_n is synchronous; it restores register defaults and clears both stages.
`default_nettype none

module stepper_motor_step_controller
  import smsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [0] first_button, [1] second_button, [7:2] zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [3:0] coil_pattern, [4] stepped, [5] sampled, [7:6] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic         in_fire;
  logic         out_pop;
  smsc_result_t result;

  logic         out_valid_r;
  smsc_result_t out_data_r;
  logic         skid_valid_r;
  smsc_result_t skid_data_r;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;

  smsc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_en       (in_fire),
    .first_button  (in_tdata[0]),
    .second_button (in_tdata[1]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result        (result)
  );

  // Output stage with skid: drain skid first, park new word when stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_pop) begin
        if (skid_valid_r) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end else if (in_fire) begin
          out_data_r <= result;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_valid_r) begin
          out_data_r  <= result;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= result;
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule

`default_nettype wire
